// ===== hw/rtl/scba_pkg.sv =====
// Package for the size-class bitmap allocator: pool geometry, field widths,
// status and operation codes, and the small helper functions.
// Depends on nothing; used by size_class_bitmap_allocator.
package scba_pkg;

  localparam int NUM_CLASSES    = 5;
  localparam int MAX_SLOT_BYTES = 64;

  localparam int BITMAP_BYTES = (1 << NUM_CLASSES) - 1;
  localparam int REGION_BYTES = MAX_SLOT_BYTES * 8;
  localparam int POOL_BYTES   = NUM_CLASSES * REGION_BYTES;

  // Slot sizes are powers of two, so the largest slot size is 1 << SLOT_LG.
  localparam int SLOT_LG   = $clog2(MAX_SLOT_BYTES + 1) - 1;
  localparam int REGION_LG = SLOT_LG + 3;

  localparam int LEN_W = 16;
  localparam int OFF_W = 12;
  localparam int CLS_W = 3;
  localparam int ST_W  = 3;
  localparam int IDX_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int BYTE_W = (NUM_CLASSES > 1) ? NUM_CLASSES - 1 : 1;
  localparam int SLOT_W = BYTE_W + 3;
  localparam int SH_W   = $clog2(REGION_LG + 1);

  localparam logic [7:0] TOP_BIT  = 8'h80;
  localparam logic [7:0] ALL_FREE = 8'hFF;

  typedef enum logic [ST_W-1:0] {
    ST_GRANTED     = 3'd0,
    ST_ZERO        = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_FULL        = 3'd3,
    ST_FREED       = 3'd4,
    ST_NOT_IN_POOL = 3'd5
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Smallest class whose slots hold the length plus a terminator, at least 4 bytes.
  function automatic logic [CLS_W-1:0] class_of_len(input logic [LEN_W-1:0] len);
    int lg;
    int ci;
    lg = 0;
    for (int i = 0; i < LEN_W; i++) begin
      if (len[i]) begin
        lg = i + 1;
      end
    end
    if (lg < 2) begin
      lg = 2;
    end
    ci = SLOT_LG - lg;
    if (ci < 0) begin
      ci = 0;
    end
    if (ci > NUM_CLASSES - 1) begin
      ci = NUM_CLASSES - 1;
    end
    return CLS_W'(ci);
  endfunction

  // First bitmap byte of a class.
  function automatic logic [IDX_W-1:0] class_base(input logic [CLS_W-1:0] c);
    return IDX_W'((1 << c) - 1);
  endfunction

endpackage

// ===== hw/rtl/size_class_bitmap_allocator.sv =====
// Size-class bitmap allocator: top level with the free bitmap, the byte scan
// sequencer and the result register. Depends on scba_pkg.
//
// A free goes from the idle state to the result state and then into the output
// register; an allocation first scans n bitmap bytes (1 to 1 << class, at most
// 16), reading one bitmap byte per cycle, until it finds a free slot or reaches
// the last byte of its class. The output register takes a result only while it
// is empty or out_stall is low. The next transaction is accepted once the result
// has moved into the output register. Synchronous reset marks every slot free at once.
module size_class_bitmap_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [scba_pkg::LEN_W-1:0]  in_length,
  input  logic [scba_pkg::OFF_W-1:0]  in_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scba_pkg::ST_W-1:0]   out_status,
  output logic [scba_pkg::OFF_W-1:0]  out_slot_offset,
  output logic [scba_pkg::CLS_W-1:0]  out_size_class
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t                          state_r;
  logic [scba_pkg::CLS_W-1:0]      class_r;
  logic [scba_pkg::BYTE_W-1:0]     byte_r;
  logic [7:0]                      bitmap_r [scba_pkg::BITMAP_BYTES];

  scba_pkg::status_t               res_status_r;
  logic [scba_pkg::OFF_W-1:0]      res_off_r;
  logic [scba_pkg::CLS_W-1:0]      res_cls_r;

  logic                            out_valid_r;
  logic [scba_pkg::ST_W-1:0]       out_status_r;
  logic [scba_pkg::OFF_W-1:0]      out_off_r;
  logic [scba_pkg::CLS_W-1:0]      out_cls_r;

  logic                            accept;
  logic                            fr_in_pool;
  logic [scba_pkg::CLS_W-1:0]      fr_cls;
  logic [scba_pkg::OFF_W-1:0]      fr_inreg;
  logic [scba_pkg::SH_W-1:0]       fr_sh;
  logic [scba_pkg::SLOT_W-1:0]     fr_slot;
  logic [scba_pkg::IDX_W-1:0]      fr_idx;
  logic [7:0]                      set_mask;
  logic [scba_pkg::IDX_W-1:0]      scan_idx;
  logic [scba_pkg::IDX_W-1:0]      rd_idx;
  logic [7:0]                      rd_byte;
  logic                            hit;
  logic [2:0]                      hit_j;
  logic [7:0]                      clr_mask;
  logic [scba_pkg::SLOT_W-1:0]     grant_slot;
  logic [scba_pkg::SH_W-1:0]       scan_sh;
  logic [scba_pkg::OFF_W-1:0]      grant_off;
  logic                            last_byte;
  logic                            out_load;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Free path: region from the offset, then the slot within the region.
  assign fr_in_pool = ({1'b0, in_offset} < (scba_pkg::OFF_W + 1)'(scba_pkg::POOL_BYTES));
  assign fr_cls     = scba_pkg::CLS_W'(in_offset >> scba_pkg::REGION_LG);
  assign fr_inreg   = in_offset & scba_pkg::OFF_W'(scba_pkg::REGION_BYTES - 1);
  assign fr_sh      = scba_pkg::SH_W'(scba_pkg::SLOT_LG) - scba_pkg::SH_W'(fr_cls);
  assign fr_slot    = scba_pkg::SLOT_W'(fr_inreg >> fr_sh);
  assign fr_idx     = scba_pkg::class_base(fr_cls) + scba_pkg::IDX_W'(fr_slot >> 3);
  assign set_mask   = scba_pkg::TOP_BIT >> fr_slot[2:0];

  // One read port serves both the scan and the free read-modify-write.
  assign scan_idx = scba_pkg::class_base(class_r) + scba_pkg::IDX_W'(byte_r);
  assign rd_idx   = (state_r == S_SCAN) ? scan_idx : fr_idx;
  assign rd_byte  = bitmap_r[rd_idx];

  // First free slot in MSB-first order.
  always_comb begin
    hit_j = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (rd_byte[7 - j]) begin
        hit_j = 3'(j);
      end
    end
  end

  assign hit        = |rd_byte;
  assign clr_mask   = ~(scba_pkg::TOP_BIT >> hit_j);
  assign grant_slot = {byte_r, hit_j};
  assign scan_sh    = scba_pkg::SH_W'(scba_pkg::SLOT_LG) - scba_pkg::SH_W'(class_r);
  assign grant_off  = (scba_pkg::OFF_W'(class_r) << scba_pkg::REGION_LG)
                    + (scba_pkg::OFF_W'(grant_slot) << scan_sh);
  assign last_byte  = (byte_r == scba_pkg::BYTE_W'((1 << class_r) - 1));

  assign out_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < scba_pkg::BITMAP_BYTES; i++) begin
        bitmap_r[i] <= scba_pkg::ALL_FREE;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_off_r <= '0;
            if (in_op == scba_pkg::OP_FREE) begin
              if (fr_in_pool) begin
                bitmap_r[fr_idx] <= rd_byte | set_mask;
                res_status_r     <= scba_pkg::ST_FREED;
                res_cls_r        <= fr_cls;
              end else begin
                res_status_r <= scba_pkg::ST_NOT_IN_POOL;
                res_cls_r    <= '0;
              end
              state_r <= S_RESP;
            end else if (in_length == '0) begin
              res_status_r <= scba_pkg::ST_ZERO;
              res_cls_r    <= '0;
              state_r      <= S_RESP;
            end else if (in_length >= scba_pkg::LEN_W'(scba_pkg::MAX_SLOT_BYTES)) begin
              res_status_r <= scba_pkg::ST_TOO_LONG;
              res_cls_r    <= '0;
              state_r      <= S_RESP;
            end else begin
              class_r <= scba_pkg::class_of_len(in_length);
              byte_r  <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            bitmap_r[scan_idx] <= rd_byte & clr_mask;
            res_status_r       <= scba_pkg::ST_GRANTED;
            res_off_r          <= grant_off;
            res_cls_r          <= class_r;
            state_r            <= S_RESP;
          end else if (last_byte) begin
            res_status_r <= scba_pkg::ST_FULL;
            res_off_r    <= '0;
            res_cls_r    <= class_r;
            state_r      <= S_RESP;
          end else begin
            byte_r <= byte_r + 1'b1;
          end
        end
        S_RESP: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_off_r    <= res_off_r;
        out_cls_r    <= res_cls_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_offset = out_off_r;
  assign out_size_class  = out_cls_r;

  // A granted slot lies in the region of the class that is reported.
  a_grant_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == scba_pkg::ST_GRANTED)
    |-> (scba_pkg::CLS_W'(out_off_r >> scba_pkg::REGION_LG) == out_cls_r))
    else $error("granted offset lies outside the reported class region");

  // Every status other than a grant carries a zero offset.
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != scba_pkg::ST_GRANTED) |-> (out_off_r == '0))
    else $error("non-granted result carries a nonzero offset");

  // The scan never reads past the bitmap bytes of its class.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (int'(byte_r) < (1 << class_r)))
    else $error("bitmap scan ran past the end of its class");

  // An accepted transaction always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start processing");

endmodule
